// File: design/ardc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ardc_pkg - shared types and constants for audio rate drift control
// Item layouts, register map, fixed-point constants and sequencer sizes.
// ----------------------------------------------------------------------------
package ardc_pkg;

  localparam int LEVEL_BITS_DEF = 24;

  localparam int CHUNK_W  = 16;
  localparam int LEVEL_W  = 24;
  localparam int RATE_W   = 18;
  localparam int RATIO_W  = 17;

  // APB register map
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-1:0] ADDR_SAMPLE_RATE = 3'd0;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST  = 18'd44100;

  // Events with fewer bytes than one sample are dropped
  localparam logic [CHUNK_W-1:0] MIN_CHUNK = 16'd4;

  // Smoothing weight 655/65536 and half-LSB for rounding
  localparam logic [9:0]  ALPHA_NUM  = 10'd655;
  localparam logic [16:0] ROUND_HALF = 17'd32768;

  localparam logic [RATIO_W-1:0] RATIO_HIGH = 17'd66847;
  localparam logic [RATIO_W-1:0] RATIO_ONE  = 17'd65536;

  // Ratio = (400*s + (2*1622016 + 25)*f) / (50*f)
  localparam logic [8:0]  DIV_S_K = 9'd400;
  localparam logic [21:0] DIV_F_K = 22'd3244057;
  localparam logic [5:0]  DIVS_K  = 6'd50;

  // Serial divider sizes: quotient never exceeds RATIO_HIGH
  localparam int DIVD_W = 40;
  localparam int DIVS_W = 24;
  localparam int DCNT_W = 5;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk_bytes;
    logic [LEVEL_W-1:0] queue_level;
  } in_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio_q16;
    logic               flush;
    logic               clamped;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

// File: design/ardc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ardc_regs - APB configuration register
// Holds the output sample rate; writes complete in the access phase.
// ----------------------------------------------------------------------------
module ardc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ardc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ardc_pkg::DATA_W-1:0]  pwdata,
  output logic [ardc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [ardc_pkg::RATE_W-1:0]  sample_rate
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ardc_pkg::ADDR_SAMPLE_RATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= ardc_pkg::SAMPLE_RATE_RST;
    end else if (wr_en) begin
      sample_rate <= pwdata[ardc_pkg::RATE_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      ardc_pkg::ADDR_SAMPLE_RATE:
        prdata = {{(ardc_pkg::DATA_W-ardc_pkg::RATE_W){1'b0}}, sample_rate};
      default: prdata = '0;
    endcase
  end

endmodule

// File: design/ardc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ardc_div - serial restoring divider
// One quotient bit per cycle; the quotient is known to fit in RATIO_W bits.
// ----------------------------------------------------------------------------
module ardc_div (
  input  logic                clk,
  input  logic                rst,
  input  ardc_pkg::div_req_t  req,
  output ardc_pkg::div_rsp_t  rsp
);

  localparam int QW = ardc_pkg::RATIO_W;
  localparam int DW = ardc_pkg::DIVS_W;

  logic [DW-1:0]                rem;
  logic [DW-1:0]                divisor;
  logic [QW-1:0]                low;
  logic [QW-1:0]                quot;
  logic [ardc_pkg::DCNT_W-1:0]  cnt;
  logic                         done;
  logic [DW:0]                  trial;
  logic                         take;

  assign trial = {rem, low[QW-1]};
  assign take  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= ardc_pkg::DCNT_W'(QW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == ardc_pkg::DCNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // Upper dividend bits are below the divisor since the quotient fits
      rem     <= DW'(req.dividend[ardc_pkg::DIVD_W-1:QW]);
      low     <= req.dividend[QW-1:0];
      divisor <= req.divisor;
      quot    <= '0;
    end else if (cnt != '0) begin
      rem  <= take ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
      low  <= {low[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], take};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

// File: design/ardc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ardc_core - fill check, smoothing filter and ratio sequencer
// Steps one event through overflow check, filter update, clamp, divide as due.
// ----------------------------------------------------------------------------
module ardc_core #(
  parameter int LEVEL_BITS = ardc_pkg::LEVEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ardc_pkg::in_t                in_data,
  input  logic [ardc_pkg::RATE_W-1:0]  sample_rate,
  input  logic                         out_free,
  output ardc_pkg::res_t               res,
  output ardc_pkg::div_req_t           div_req,
  input  ardc_pkg::div_rsp_t           div_rsp
);

  localparam int SW    = LEVEL_BITS + 8;
  localparam int CMPW  = (LEVEL_BITS > ardc_pkg::LEVEL_W) ? LEVEL_BITS : ardc_pkg::LEVEL_W;
  localparam int PW    = SW + 11;
  localparam int CLW   = (SW + 8 > 34) ? SW + 8 : 34;
  localparam int EXT_W = (SW + 9 > 41) ? SW + 9 : 41;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_PROD   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_CLAMP  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                  state;
  logic [ardc_pkg::LEVEL_W-1:0] level;
  logic [SW-1:0]               smoothed;
  logic                        primed;
  logic [SW-1:0]               fill;
  logic                        flush;
  logic signed [PW-1:0]        prod;
  ardc_pkg::out_t              result;

  // overflow check
  logic [30:0]                 lvl100;
  logic [30:0]                 f256;
  logic                        over;
  logic [CMPW-1:0]             lvl_ext;
  logic [CMPW-1:0]             lvl_cap;
  logic [CMPW-1:0]             lvl_sat;
  logic [SW-1:0]               fill_next;

  // filter update
  logic signed [SW:0]          diff;
  logic signed [PW-1:0]        prod_next;
  logic signed [PW-1:0]        adj;
  logic signed [PW-1:0]        sum;

  // clamp and divide operands
  logic [CLW-1:0]              s200;
  logic [CLW-1:0]              f49152;
  logic                        high;
  logic [EXT_W-1:0]            dividend;
  logic [ardc_pkg::DIVS_W-1:0] divisor;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    lvl100    = (31'(level) << 6) + (31'(level) << 5) + (31'(level) << 2);
    f256      = 31'({sample_rate, 8'b0});
    over      = (lvl100 > f256);
    lvl_ext   = over ? '0 : CMPW'(level);
    lvl_cap   = CMPW'({LEVEL_BITS{1'b1}});
    lvl_sat   = (lvl_ext > lvl_cap) ? lvl_cap : lvl_ext;
    fill_next = {lvl_sat[LEVEL_BITS-1:0], 8'b0};
  end

  always_comb begin
    diff      = $signed({1'b0, fill}) - $signed({1'b0, smoothed});
    prod_next = PW'(diff) * PW'($signed({1'b0, ardc_pkg::ALPHA_NUM}));
    adj       = (prod + PW'($signed({1'b0, ardc_pkg::ROUND_HALF}))) >>> 16;
    sum       = $signed(PW'({1'b0, smoothed})) + adj;
  end

  always_comb begin
    s200     = (CLW'(smoothed) << 7) + (CLW'(smoothed) << 6) + (CLW'(smoothed) << 3);
    f49152   = (CLW'(sample_rate) << 15) + (CLW'(sample_rate) << 14);
    high     = (s200 > f49152);
    dividend = EXT_W'(smoothed) * EXT_W'(ardc_pkg::DIV_S_K)
             + EXT_W'(sample_rate) * EXT_W'(ardc_pkg::DIV_F_K);
    divisor  = ardc_pkg::DIVS_W'(sample_rate) * ardc_pkg::DIVS_W'(ardc_pkg::DIVS_K);
  end

  always_comb begin
    div_req.start    = (state == S_CLAMP) && (sample_rate != '0) && !high;
    div_req.dividend = dividend[ardc_pkg::DIVD_W-1:0];
    div_req.divisor  = divisor;
  end

  assign res.valid = (state == S_DONE) && out_free;
  assign res.data  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      primed   <= 1'b0;
      smoothed <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          // drop short chunks outright
          if (in_valid && in_data.chunk_bytes >= ardc_pkg::MIN_CHUNK) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!primed || over) begin
            smoothed <= fill_next;
            primed   <= 1'b1;
            state    <= S_CLAMP;
          end else begin
            state <= S_PROD;
          end
        end
        S_PROD:   state <= S_UPDATE;
        S_UPDATE: begin
          smoothed <= sum[SW-1:0];
          state    <= S_CLAMP;
        end
        S_CLAMP: begin
          state <= div_req.start ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      level <= in_data.queue_level;
    end
    if (state == S_CHECK) begin
      fill  <= fill_next;
      flush <= over;
    end
    if (state == S_PROD) begin
      prod <= prod_next;
    end
    if (state == S_CLAMP) begin
      result.flush <= flush;
      if (sample_rate == '0) begin
        result.ratio_q16 <= ardc_pkg::RATIO_ONE;
        result.clamped   <= 1'b0;
      end else if (high) begin
        result.ratio_q16 <= ardc_pkg::RATIO_HIGH;
        result.clamped   <= 1'b1;
      end
    end
    if (state == S_DIV && div_rsp.done) begin
      if (div_rsp.quotient > ardc_pkg::RATIO_HIGH) begin
        result.ratio_q16 <= ardc_pkg::RATIO_HIGH;
        result.clamped   <= 1'b1;
      end else begin
        result.ratio_q16 <= div_rsp.quotient;
        result.clamped   <= 1'b0;
      end
    end
  end

endmodule

// File: design/audio_rate_drift_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_rate_drift_control - playback ratio control from output queue fill
// Smooths the measured queue fill and turns its drift from target into a
// clamped Q16 frequency ratio, flagging queue overflow.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  in        in_valid / in_ready        in_data   (chunk_bytes, queue_level)
//  out       out_valid / out_ready      out_data  (ratio_q16, flush, clamped)
//  cfg       psel penable pwrite pready paddr pwdata prdata (sample_rate)
//
//  A chunk below 4 bytes is consumed in its accept cycle and gives no item.
//  Other events pass the check, product, update and clamp states, then the
//  17-step serial divider unless the ratio clamps or the rate is zero, into the
//  output register; an event that primes the filter or flushes skips product and update.
//  in_ready stays low until the result is registered; a stalled output holds
//  the sequencer in its last step. Synchronous reset clears filter and valids.
// ----------------------------------------------------------------------------
module audio_rate_drift_control #(
  parameter int LEVEL_BITS = ardc_pkg::LEVEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ardc_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ardc_pkg::out_t               out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ardc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ardc_pkg::DATA_W-1:0]  pwdata,
  output logic [ardc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [ardc_pkg::RATE_W-1:0] sample_rate;
  logic                        out_free;
  ardc_pkg::res_t              res;
  ardc_pkg::div_req_t          div_req;
  ardc_pkg::div_rsp_t          div_rsp;

  ardc_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .sample_rate (sample_rate)
  );

  ardc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ardc_core #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .sample_rate (sample_rate),
    .out_free    (out_free),
    .res         (res),
    .div_req     (div_req),
    .div_rsp     (div_rsp)
  );

  // Output register: free when empty or being taken this cycle
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data <= res.data;
    end
  end

endmodule

// File: design/ardc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ardc_checker - port-level checks for audio rate drift control
// Watches the item channels and binds to the top level.
// ----------------------------------------------------------------------------
module ardc_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input ardc_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input ardc_pkg::out_t out_data
);

  // A held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.ratio_q16 >= 17'd64225) && (out_data.ratio_q16 <= 17'd66847))
    else $error("ratio outside limits");

  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clamped |-> out_data.ratio_q16 == 17'd66847)
    else $error("clamped item without limit ratio");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.chunk_bytes >= 16'd4) |=> !in_ready)
    else $error("input taken while event in progress");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind audio_rate_drift_control ardc_checker u_ardc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
